FILE: sv/lbr_pkg.sv
`default_nettype none
package lbr_pkg;
  localparam int MAX_SRC_WIDTH_C  = 256;
  localparam int MAX_SRC_HEIGHT_C = 256;
  localparam int MAX_CHANNELS_C   = 3;
  localparam int MAX_DST_DIM_C    = 1024;

  localparam logic [15:0] HALF_Q15 = 16'd16384;
  localparam logic [16:0] ONE_Q15  = 17'd32768;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [2:0] CFG_SRC_W = 3'd0;
  localparam logic [2:0] CFG_SRC_H = 3'd1;
  localparam logic [2:0] CFG_NCH   = 3'd2;
  localparam logic [2:0] CFG_DST_W = 3'd3;
  localparam logic [2:0] CFG_DST_H = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIT_MUL, ST_FIT_CMP, ST_FIT_DIV, ST_FIT_OFS, ST_CHECK,
    ST_DIV_Y, ST_DIV_FY, ST_ROW_START, ST_DIV_X, ST_DIV_FX,
    ST_RD0, ST_RD1, ST_RD_WAIT, ST_HBLEND, ST_VBLEND, ST_OUT
  } lbr_state_t;

  typedef enum logic [1:0] {
    DV_FIT, DV_Y, DV_X
  } lbr_dsel_t;
endpackage
`default_nettype wire

FILE: sv/lbr_stream_if.sv
`default_nettype none
interface lbr_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/letterbox_bilinear_resize_unit.sv
// Loads may follow back to back; reads are handled one at a time.
// Reads use a shared 25-step divider: an absent plane skips it, a border pixel stops after
// the fit, a fit of one reads one sample, and an interior pixel runs the fit, row index and
// fraction, then column index and fraction for up to two rows, plus single-port store reads.
// A result waits in the output register while further requests are accepted.
// Sync active-low reset clears control and loads register defaults; store is not cleared.
`default_nettype none
module letterbox_bilinear_resize_unit
  import lbr_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_C,
  parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_C,
  parameter int MAX_CHANNELS   = MAX_CHANNELS_C,
  parameter int MAX_DST_DIM    = MAX_DST_DIM_C
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  in_req_type,
  input  wire logic [15:0] in_sample_in,
  input  wire logic [9:0]  in_pos_x,
  input  wire logic [9:0]  in_pos_y,
  input  wire logic [1:0]  in_chan_sel,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [15:0] out_pixel_value,
  output logic       out_is_padding,
  input  wire logic  cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;
  localparam int AW = $clog2(DEPTH);
  localparam int DW = 25;   // divider width
  localparam int DSTEPS = DW;

  // channel interfaces
  lbr_stream_if #(.W(39)) in_ch ();
  lbr_stream_if #(.W(17)) out_ch ();
  assign in_ch.valid = in_valid;
  assign in_ch.data  = {in_req_type, in_sample_in, in_pos_x, in_pos_y, in_chan_sel};
  assign in_ready    = in_ch.ready;
  assign out_valid   = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_pixel_value = out_ch.data[16:1];
  assign out_is_padding  = out_ch.data[0];

  // configuration
  logic [8:0]  src_w_r, src_h_r;
  logic [1:0]  nch_r;
  logic [10:0] dst_w_r, dst_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256; src_h_r <= 9'd256; nch_r <= 2'd3;
      dst_w_r <= 11'd416; dst_h_r <= 11'd416;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_W: src_w_r <= cfg_data[8:0];
        CFG_SRC_H: src_h_r <= cfg_data[8:0];
        CFG_NCH:   nch_r   <= cfg_data[1:0];
        CFG_DST_W: dst_w_r <= cfg_data;
        CFG_DST_H: dst_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [12:0] clampv(input logic [12:0] v, input int hi);
    if (v == 13'd0) return 13'd1;
    if (v > 13'(hi)) return 13'(hi);
    return v;
  endfunction

  logic [12:0] sw, sh, dw, dh;
  logic [2:0]  nc;
  assign sw = clampv({4'd0, src_w_r}, MAX_SRC_WIDTH);
  assign sh = clampv({4'd0, src_h_r}, MAX_SRC_HEIGHT);
  assign dw = clampv({2'd0, dst_w_r}, MAX_DST_DIM);
  assign dh = clampv({2'd0, dst_h_r}, MAX_DST_DIM);
  assign nc = (nch_r == 2'd0) ? 3'd1 :
              ({1'b0, nch_r} > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : {1'b0, nch_r};

  // request fields
  logic        rq_type;
  logic [15:0] rq_smp;
  logic [9:0]  rq_x, rq_y;
  logic [1:0]  rq_ch;
  assign {rq_type, rq_smp, rq_x, rq_y, rq_ch} = in_ch.data;

  // image store
  logic [15:0] mem [DEPTH];
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_rd_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= rq_smp;
    mem_rd_r <= mem[mem_ra];
  end

  function automatic logic [AW-1:0] addr(input logic [1:0] c, input logic [12:0] y,
                                         input logic [12:0] x);
    logic [AW+13:0] a;
    a = (AW+14)'(c) * (AW+14)'(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
      + (AW+14)'(y) * (AW+14)'(MAX_SRC_WIDTH) + (AW+14)'(x);
    return a[AW-1:0];
  endfunction

  // working registers
  lbr_state_t st_r, st_nxt;
  logic [1:0]  ch_r;
  logic [9:0]  x_r, y_r;
  logic [23:0] p0_r, p1_r;
  logic [12:0] fw_r, fh_r, ox_r, oy_r, u_r;
  logic [12:0] iy_r, ix_r, rowy_r;
  logic [15:0] fy_r, fx_r;
  logic [15:0] s0_r, h0_r;
  logic        edge_x_r, row1_r, second_r;
  logic [16:0] res_r, wres_r;
  logic        ov_r;

  // shared restoring divider: quotient and remainder of num/den
  logic [DW-1:0] dn_r, dd_r, dq_r, drem_r;
  logic [4:0]    dcnt_r;
  logic          dbusy_r, dstart;
  logic [DW-1:0] dstart_n, dstart_d;
  logic [DW:0]   dtrial;
  assign dtrial = {drem_r, dn_r[DW-1]} - {1'b0, dd_r};
  always_ff @(posedge clk) begin
    if (!rst_n) dbusy_r <= 1'b0;
    else if (dstart) begin
      dbusy_r <= 1'b1; dcnt_r <= 5'(DSTEPS);
      dn_r <= dstart_n; dd_r <= dstart_d; drem_r <= '0; dq_r <= '0;
    end else if (dbusy_r) begin
      dn_r <= dn_r << 1;
      if (!dtrial[DW]) begin
        drem_r <= dtrial[DW-1:0]; dq_r <= {dq_r[DW-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[DW-2:0], dn_r[DW-1]}; dq_r <= {dq_r[DW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 5'd1;
      if (dcnt_r == 5'd1) dbusy_r <= 1'b0;
    end
  end
  logic ddone;
  assign ddone = dbusy_r && dcnt_r == 5'd1;
  logic [DW-1:0] dq_fin, dr_fin;
  assign dq_fin = {dq_r[DW-2:0], ~dtrial[DW]};
  assign dr_fin = dtrial[DW] ? {drem_r[DW-2:0], dn_r[DW-1]} : dtrial[DW-1:0];

  logic fit_w_r;   // fitted width equals dst width
  logic fit_w_c;
  logic [12:0] fden;
  assign fit_w_c = p0_r < p1_r;
  assign fden = fit_w_c ? sw : sh;

  logic pad, idle_ok, out_free;
  assign pad = fw_r == 13'd0 || fh_r == 13'd0 || {3'd0, x_r} >= dw || {3'd0, y_r} >= dh ||
               {3'd0, x_r} < ox_r || {3'd0, x_r} >= ox_r + fw_r ||
               {3'd0, y_r} < oy_r || {3'd0, y_r} >= oy_r + fh_r;

  assign out_free = !ov_r || out_ch.ready;
  assign idle_ok = st_r == ST_IDLE;
  assign in_ch.ready = idle_ok;
  assign out_ch.valid = ov_r;
  assign out_ch.data = res_r;

  // blend
  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] f);
    logic [33:0] s;
    s = 34'(ONE_Q15 - {1'b0, f}) * 34'(a) + 34'(f) * 34'(b) + 34'(HALF_Q15);
    return s[30:15];
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:      if (in_ch.valid && idle_ok && rq_type == REQ_READ)
                      st_nxt = ST_FIT_MUL;
      ST_FIT_MUL:   st_nxt = ({1'b0, ch_r} >= nc) ? ST_OUT : ST_FIT_CMP;
      ST_FIT_CMP:   st_nxt = ST_FIT_DIV;
      ST_FIT_DIV:   if (ddone) st_nxt = ST_FIT_OFS;
      ST_FIT_OFS:   st_nxt = ST_CHECK;
      ST_CHECK:     st_nxt = pad ? ST_OUT :
                             (fw_r == 13'd1 || fh_r == 13'd1) ? ST_RD0 : ST_DIV_Y;
      ST_DIV_Y:     if (ddone) st_nxt = ST_DIV_FY;
      ST_DIV_FY:    if (ddone) st_nxt = ST_ROW_START;
      ST_ROW_START: st_nxt = edge_x_r ? ST_RD1 : ST_DIV_X;
      ST_DIV_X:     if (ddone) st_nxt = ST_DIV_FX;
      ST_DIV_FX:    if (ddone) st_nxt = ST_RD0;
      ST_RD0:       st_nxt = (fw_r == 13'd1 || fh_r == 13'd1) ? ST_RD_WAIT : ST_RD1;
      ST_RD1:       st_nxt = ST_RD_WAIT;
      ST_RD_WAIT:   st_nxt = (fw_r == 13'd1 || fh_r == 13'd1) ? ST_OUT : ST_HBLEND;
      ST_HBLEND:    st_nxt = (second_r || !row1_r) ? ST_VBLEND : ST_ROW_START;
      ST_VBLEND:    st_nxt = ST_OUT;
      ST_OUT:       if (out_free) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  logic [12:0] colx;
  always_comb begin
    mem_we = in_ch.valid && idle_ok && rq_type == REQ_LOAD &&
             {3'd0, rq_x} < sw && {3'd0, rq_y} < sh && {1'b0, rq_ch} < nc;
    mem_wa = addr(rq_ch, {3'd0, rq_y}, {3'd0, rq_x});
    colx = edge_x_r ? sw - 13'd1 : ix_r;
    // the read address is held through the wait state
    mem_ra = addr(ch_r, rowy_r, (st_r == ST_RD0 || edge_x_r) ? colx : colx + 13'd1);
    if (fw_r == 13'd1 || fh_r == 13'd1) mem_ra = addr(ch_r, 13'd0, 13'd0);
    dstart = 1'b0; dstart_n = '0; dstart_d = DW'(1);
    case (st_r)
      ST_FIT_CMP: begin
        dstart = 1'b1;
        dstart_n = fit_w_c ? DW'(sh) * DW'(dw) : DW'(sw) * DW'(dh);
        dstart_d = DW'(fden);
      end
      ST_CHECK: begin
        dstart = !pad && fw_r != 13'd1 && fh_r != 13'd1;
        dstart_n = DW'(({3'd0, y_r} - oy_r)) * DW'(sh - 13'd1);
        dstart_d = DW'(fh_r - 13'd1);
      end
      ST_DIV_Y: begin
        dstart = ddone; dstart_n = {dr_fin[9:0], 15'd0}; dstart_d = DW'(fh_r - 13'd1);
      end
      ST_ROW_START: begin
        dstart = !edge_x_r;
        dstart_n = DW'(u_r) * DW'(sw - 13'd1); dstart_d = DW'(fw_r - 13'd1);
      end
      ST_DIV_X: begin
        dstart = ddone; dstart_n = {dr_fin[9:0], 15'd0}; dstart_d = DW'(fw_r - 13'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_OUT && out_free) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        ch_r <= rq_ch; x_r <= rq_x; y_r <= rq_y; second_r <= 1'b0;
      end
      ST_FIT_MUL: begin
        p0_r <= 24'(dw) * 24'(sh); p1_r <= 24'(dh) * 24'(sw);
        wres_r <= 17'd0;
      end
      ST_FIT_CMP: fit_w_r <= fit_w_c;
      ST_FIT_DIV: if (ddone) begin
        if (fit_w_r) begin fw_r <= dw; fh_r <= dq_fin[12:0]; end
        else begin fh_r <= dh; fw_r <= dq_fin[12:0]; end
      end
      ST_FIT_OFS: begin
        ox_r <= (dw - fw_r) >> 1; oy_r <= (dh - fh_r) >> 1;
      end
      ST_CHECK: begin
        wres_r <= {HALF_Q15, 1'b1};
        u_r <= {3'd0, x_r} - ox_r;
        edge_x_r <= ({3'd0, x_r} - ox_r) == fw_r - 13'd1 || sw == 13'd1;
        row1_r <= !(({3'd0, y_r} - oy_r) == fh_r - 13'd1 || sh == 13'd1);
      end
      ST_DIV_Y: if (ddone) begin iy_r <= dq_fin[12:0]; rowy_r <= dq_fin[12:0]; end
      ST_DIV_FY: if (ddone) fy_r <= dq_fin[15:0];
      ST_DIV_X: if (ddone) ix_r <= dq_fin[12:0];
      ST_DIV_FX: if (ddone) fx_r <= dq_fin[15:0];
      ST_RD1: s0_r <= mem_rd_r;
      ST_RD_WAIT: if (fw_r == 13'd1 || fh_r == 13'd1) wres_r <= {mem_rd_r, 1'b0};
      ST_HBLEND: begin
        if (!second_r) h0_r <= edge_x_r ? mem_rd_r : blend(s0_r, mem_rd_r, fx_r);
        else s0_r <= edge_x_r ? mem_rd_r : blend(s0_r, mem_rd_r, fx_r);
        second_r <= 1'b1; rowy_r <= iy_r + 13'd1;
      end
      ST_VBLEND: wres_r <= {row1_r ? blend(h0_r, s0_r, fy_r) : h0_r, 1'b0};
      ST_OUT: if (out_free) res_r <= wres_r;
      default: ;
    endcase
  end
endmodule
`default_nettype wire
